/* hdl/palm_zone_rejector_macros.svh */
// ----------------------------------------------------------------------------
// Palm zone rejector assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef PALM_ZONE_REJECTOR_MACROS_SVH
`define PALM_ZONE_REJECTOR_MACROS_SVH

// Check a property at every clock edge outside reset
`define PZR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent
`define PZR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/pzr_pkg.sv */
// ----------------------------------------------------------------------------
// Palm zone rejector package
// Field widths, register codes, reset values and channel payload types.
// ----------------------------------------------------------------------------
package pzr_pkg;

  // Heatmap grid and counter defaults
  localparam int unsigned GRID_ROWS     = 40;
  localparam int unsigned GRID_COLS     = 60;
  localparam int unsigned COUNT_MAX_DEF = 255;

  // Field widths
  localparam int unsigned COORD_W     = 6;
  localparam int unsigned SIG_W       = 16;
  localparam int unsigned AREA_W      = 12;
  localparam int unsigned SUM_W       = 27;
  localparam int unsigned FLOOR_W     = 23;
  localparam int unsigned ASPECT_W    = 14;
  localparam int unsigned REASON_W    = 3;
  localparam int unsigned COUNT_OUT_W = 8;
  localparam int unsigned SPAN_W      = COORD_W + 1;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Register reset values
  localparam logic                RST_BLOCK_ENABLED  = 1'b1;
  localparam logic [AREA_W-1:0]   RST_AREA_LIMIT     = {AREA_W{1'b1}};
  localparam logic [SUM_W-1:0]    RST_SUM_LIMIT      = SUM_MAX;
  localparam logic [AREA_W-1:0]   RST_DENS_MIN_AREA  = {AREA_W{1'b1}};
  localparam logic [FLOOR_W-1:0]  RST_DENS_FLOOR     = '0;
  localparam logic                RST_ELONG_ENABLED  = 1'b0;
  localparam logic [AREA_W-1:0]   RST_ELONG_MIN_AREA = {AREA_W{1'b1}};
  localparam logic [ASPECT_W-1:0] RST_ASPECT_LIMIT   = {ASPECT_W{1'b1}};

  // Bounding box values of an empty zone
  localparam logic [COORD_W-1:0] ROW_LOW_RST = COORD_W'(GRID_ROWS - 1);
  localparam logic [COORD_W-1:0] COL_LOW_RST = COORD_W'(GRID_COLS - 1);

  // Register indexes, word addressed on the configuration port
  typedef enum logic [2:0] {
    REG_BLOCK_ENABLED  = 3'd0,
    REG_AREA_LIMIT     = 3'd1,
    REG_SUM_LIMIT      = 3'd2,
    REG_DENS_MIN_AREA  = 3'd3,
    REG_DENS_FLOOR     = 3'd4,
    REG_ELONG_ENABLED  = 3'd5,
    REG_ELONG_MIN_AREA = 3'd6,
    REG_ASPECT_LIMIT   = 3'd7
  } reg_idx_e;

  // Reject reasons
  typedef enum logic [REASON_W-1:0] {
    RSN_KEPT      = 3'd0,
    RSN_AREA      = 3'd1,
    RSN_SUM       = 3'd2,
    RSN_DENSITY   = 3'd3,
    RSN_ELONGATED = 3'd4
  } reason_e;

  // One zone pixel request
  typedef struct packed {
    logic [COORD_W-1:0]      pixel_row;
    logic [COORD_W-1:0]      pixel_col;
    logic signed [SIG_W-1:0] pixel_signal;
    logic [AREA_W-1:0]       zone_area;
    logic                    last_pixel;
    logic                    last_zone;
  } pixel_t;

  // One zone verdict
  typedef struct packed {
    logic                   zone_rejected;
    logic [REASON_W-1:0]    reject_reason;
    logic [COUNT_OUT_W-1:0] frame_reject_count;
  } result_t;

endpackage

/* hdl/pzr_if.sv */
// ----------------------------------------------------------------------------
// Palm zone rejector channels
// Valid/ready interfaces for the pixel stream and the verdict stream.
// ----------------------------------------------------------------------------
interface pzr_pixel_if;
  logic            valid;
  logic            ready;
  pzr_pkg::pixel_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pzr_result_if;
  logic             valid;
  logic             ready;
  pzr_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/palm_zone_rejector.sv */
// ----------------------------------------------------------------------------
// Palm zone rejector
// Accumulates zone pixels and judges each finished zone as palm or finger.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake           | payload
//  pixel_i   | in        | valid/ready         | row, col, signal, area, last marks
//  result_o  | out       | valid/ready         | reject flag, reason, frame count
//  apb       | in        | psel/penable/pready | 8 word registers, 32-bit data
//
//  One pixel request per cycle unless a last pixel waits for the result register;
//  a verdict is judged in one pass from the input register to the result register.
//  A pending verdict stalls only a following last pixel; other pixels keep moving.
//  Reset clears the zone sum, the bounding box, the frame count and loads the
//  register defaults.
// ----------------------------------------------------------------------------
`include "palm_zone_rejector_macros.svh"

module palm_zone_rejector #(
  parameter int unsigned COUNT_MAX = pzr_pkg::COUNT_MAX_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  pzr_pixel_if.sink                       pixel_i,
  pzr_result_if.source                    result_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pzr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [pzr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [pzr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import pzr_pkg::*;

  localparam int unsigned CNT_W = $clog2(COUNT_MAX + 1);

  // Configuration registers
  logic                block_enabled_q;
  logic [AREA_W-1:0]   area_limit_q;
  logic [SUM_W-1:0]    sum_limit_q;
  logic [AREA_W-1:0]   dens_min_area_q;
  logic [FLOOR_W-1:0]  dens_floor_q;
  logic                elong_enabled_q;
  logic [AREA_W-1:0]   elong_min_area_q;
  logic [ASPECT_W-1:0] aspect_limit_q;

  reg_idx_e cfg_idx;
  logic     cfg_wr;

  // Pipeline registers
  pixel_t  in_q;
  logic    in_valid_q;
  result_t out_q;
  logic    out_valid_q;

  // Zone and frame state
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [COORD_W-1:0] row_lo_q, row_lo_d, row_hi_q, row_hi_d;
  logic [COORD_W-1:0] col_lo_q, col_lo_d, col_hi_q, col_hi_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic out_free, advance, take;

  logic              sig_pos;
  logic [SUM_W:0]    sum_ext;
  logic [SPAN_W-1:0] span_w, span_h, lng, sht;
  logic [SUM_W+7:0]  dens_lhs, dens_rhs;
  logic [ASPECT_W+SPAN_W-1:0] asp_lhs, asp_rhs;
  reason_e           reason;
  logic              reject;
  logic [CNT_W+COUNT_OUT_W-1:0] cnt_ext;

  // Decode configuration requests
  assign cfg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_enabled_q  <= RST_BLOCK_ENABLED;
      area_limit_q     <= RST_AREA_LIMIT;
      sum_limit_q      <= RST_SUM_LIMIT;
      dens_min_area_q  <= RST_DENS_MIN_AREA;
      dens_floor_q     <= RST_DENS_FLOOR;
      elong_enabled_q  <= RST_ELONG_ENABLED;
      elong_min_area_q <= RST_ELONG_MIN_AREA;
      aspect_limit_q   <= RST_ASPECT_LIMIT;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BLOCK_ENABLED:  block_enabled_q  <= pwdata[0];
        REG_AREA_LIMIT:     area_limit_q     <= pwdata[AREA_W-1:0];
        REG_SUM_LIMIT:      sum_limit_q      <= pwdata[SUM_W-1:0];
        REG_DENS_MIN_AREA:  dens_min_area_q  <= pwdata[AREA_W-1:0];
        REG_DENS_FLOOR:     dens_floor_q     <= pwdata[FLOOR_W-1:0];
        REG_ELONG_ENABLED:  elong_enabled_q  <= pwdata[0];
        REG_ELONG_MIN_AREA: elong_min_area_q <= pwdata[AREA_W-1:0];
        REG_ASPECT_LIMIT:   aspect_limit_q   <= pwdata[ASPECT_W-1:0];
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (cfg_idx)
      REG_BLOCK_ENABLED:  prdata = CFG_DATA_W'(block_enabled_q);
      REG_AREA_LIMIT:     prdata = CFG_DATA_W'(area_limit_q);
      REG_SUM_LIMIT:      prdata = CFG_DATA_W'(sum_limit_q);
      REG_DENS_MIN_AREA:  prdata = CFG_DATA_W'(dens_min_area_q);
      REG_DENS_FLOOR:     prdata = CFG_DATA_W'(dens_floor_q);
      REG_ELONG_ENABLED:  prdata = CFG_DATA_W'(elong_enabled_q);
      REG_ELONG_MIN_AREA: prdata = CFG_DATA_W'(elong_min_area_q);
      REG_ASPECT_LIMIT:   prdata = CFG_DATA_W'(aspect_limit_q);
    endcase
  end

  // Flow control: only a last pixel needs room in the result register
  assign out_free      = !out_valid_q || result_o.ready;
  assign advance       = in_valid_q && (!in_q.last_pixel || out_free);
  assign pixel_i.ready = !in_valid_q || advance;
  assign take          = pixel_i.valid && pixel_i.ready;

  // Hold the input request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= pixel_i.payload;
    end
  end

  // Accumulate positive signal, saturating
  always_comb begin
    sig_pos = !in_q.pixel_signal[SIG_W-1] && (in_q.pixel_signal != '0);
    sum_ext = {1'b0, sum_q} +
              (sig_pos ? (SUM_W+1)'(in_q.pixel_signal[SIG_W-2:0]) : '0);
    sum_d   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
  end

  // Grow the bounding box
  always_comb begin
    row_lo_d = (in_q.pixel_row < row_lo_q) ? in_q.pixel_row : row_lo_q;
    row_hi_d = (in_q.pixel_row > row_hi_q) ? in_q.pixel_row : row_hi_q;
    col_lo_d = (in_q.pixel_col < col_lo_q) ? in_q.pixel_col : col_lo_q;
    col_hi_d = (in_q.pixel_col > col_hi_q) ? in_q.pixel_col : col_hi_q;
  end

  // Box sides, long and short
  always_comb begin
    span_w = (col_hi_d >= col_lo_d) ?
             ({1'b0, col_hi_d} - {1'b0, col_lo_d} + SPAN_W'(1)) : SPAN_W'(1);
    span_h = (row_hi_d >= row_lo_d) ?
             ({1'b0, row_hi_d} - {1'b0, row_lo_d} + SPAN_W'(1)) : SPAN_W'(1);
    lng    = (span_w > span_h) ? span_w : span_h;
    sht    = (span_w > span_h) ? span_h : span_w;
  end

  // Density and aspect tests, multiplied through
  always_comb begin
    dens_lhs = {sum_d, 8'd0};
    dens_rhs = (SUM_W+8)'(dens_floor_q) * (SUM_W+8)'(in_q.zone_area);
    asp_lhs  = (ASPECT_W+SPAN_W)'({lng, 8'd0});
    asp_rhs  = (ASPECT_W+SPAN_W)'(aspect_limit_q) * (ASPECT_W+SPAN_W)'(sht);
  end

  // Apply the rules in order
  always_comb begin
    priority if (in_q.zone_area >= area_limit_q) begin
      reason = RSN_AREA;
    end else if (sum_d >= sum_limit_q) begin
      reason = RSN_SUM;
    end else if ((in_q.zone_area >= dens_min_area_q) && (in_q.zone_area != '0) &&
                 (dens_lhs < dens_rhs)) begin
      reason = RSN_DENSITY;
    end else if (elong_enabled_q && (in_q.zone_area >= elong_min_area_q) &&
                 (asp_lhs >= asp_rhs)) begin
      reason = RSN_ELONGATED;
    end else begin
      reason = RSN_KEPT;
    end
  end

  // Count rejections, saturating
  always_comb begin
    reject  = block_enabled_q && (reason != RSN_KEPT);
    cnt_d   = (reject && (cnt_q < CNT_W'(COUNT_MAX))) ? (cnt_q + CNT_W'(1)) : cnt_q;
    cnt_ext = {{COUNT_OUT_W{1'b0}}, cnt_d};
  end

  // Advance zone and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      row_lo_q <= ROW_LOW_RST;
      row_hi_q <= '0;
      col_lo_q <= COL_LOW_RST;
      col_hi_q <= '0;
      cnt_q    <= '0;
    end else if (advance) begin
      if (in_q.last_pixel) begin
        sum_q    <= '0;
        row_lo_q <= ROW_LOW_RST;
        row_hi_q <= '0;
        col_lo_q <= COL_LOW_RST;
        col_hi_q <= '0;
        cnt_q    <= in_q.last_zone ? '0 : cnt_d;
      end else begin
        sum_q    <= sum_d;
        row_lo_q <= row_lo_d;
        row_hi_q <= row_hi_d;
        col_lo_q <= col_lo_d;
        col_hi_q <= col_hi_d;
      end
    end
  end

  // Load the verdict, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_q.last_pixel) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_q.last_pixel) begin
      out_q.zone_rejected      <= reject;
      out_q.reject_reason      <= reject ? reason : RSN_KEPT;
      out_q.frame_reject_count <= cnt_ext[COUNT_OUT_W-1:0];
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

  // Checks
  `PZR_ASSERT(a_flag_matches_reason,
    out_valid_q |-> (out_q.zone_rejected == (out_q.reject_reason != RSN_KEPT)),
    "reject flag disagrees with reason")
  `PZR_ASSERT(a_count_bounded, cnt_q <= CNT_W'(COUNT_MAX), "frame count above maximum")
  `PZR_ASSERT(a_verdict_from_last, $rose(out_valid_q) |-> $past(advance && in_q.last_pixel),
    "verdict without a last pixel")
  `PZR_ASSERT_NEXT(a_zone_cleared, advance && in_q.last_pixel,
    sum_q == '0 && row_hi_q == '0 && col_hi_q == '0, "zone state not cleared")
  `PZR_ASSERT_NEXT(a_count_held, advance && !in_q.last_pixel, $stable(cnt_q),
    "frame count moved on an inner pixel")

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Palm zone rejector testbench
// Streams zone pixels through the rejector with random stalls on both
// channels, predicts every zone verdict from a local copy of the zone sum,
// bounding box, frame count and registers, and compares each verdict field
// by field. Directed zones hit each rule and corner first; random phases
// under varied register settings, a long receiver hold-off, a frame count
// saturation run and a long zone of full-scale pixels follow.
// ----------------------------------------------------------------------------
module testbench;
  import pzr_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam logic [FLOOR_W-1:0]  FLOOR_MAX  = {FLOOR_W{1'b1}};
  localparam logic [AREA_W-1:0]   AREA_MAX   = {AREA_W{1'b1}};
  localparam logic [ASPECT_W-1:0] ASPECT_MAX = {ASPECT_W{1'b1}};

  // One full register setting
  typedef struct packed {
    logic                block_on;
    logic [AREA_W-1:0]   area_max;
    logic [SUM_W-1:0]    sum_max;
    logic [AREA_W-1:0]   dens_area;
    logic [FLOOR_W-1:0]  dens_floor;
    logic                elong_on;
    logic [AREA_W-1:0]   elong_area;
    logic [ASPECT_W-1:0] aspect_q8;
  } tuning_t;

  // Zone verdict predictor and the verdicts still owed by the block
  class zone_verdicts;
    tuning_t              cfg;
    logic [SUM_W-1:0]     zone_sum;
    logic [COORD_W-1:0]   row_lo, row_hi, col_lo, col_hi;
    int unsigned          frame_rejects;
    result_t              owed_q[$];
    int unsigned          errors;

    function void power_on();
      cfg = '{RST_BLOCK_ENABLED, RST_AREA_LIMIT, RST_SUM_LIMIT, RST_DENS_MIN_AREA,
              RST_DENS_FLOOR, RST_ELONG_ENABLED, RST_ELONG_MIN_AREA, RST_ASPECT_LIMIT};
      clear_zone();
      frame_rejects = 0;
      errors = 0;
    endfunction

    function void clear_zone();
      zone_sum = '0;
      row_lo = ROW_LOW_RST;
      row_hi = '0;
      col_lo = COL_LOW_RST;
      col_hi = '0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_BLOCK_ENABLED:  cfg.block_on   = value[0];
        REG_AREA_LIMIT:     cfg.area_max   = value[AREA_W-1:0];
        REG_SUM_LIMIT:      cfg.sum_max    = value[SUM_W-1:0];
        REG_DENS_MIN_AREA:  cfg.dens_area  = value[AREA_W-1:0];
        REG_DENS_FLOOR:     cfg.dens_floor = value[FLOOR_W-1:0];
        REG_ELONG_ENABLED:  cfg.elong_on   = value[0];
        REG_ELONG_MIN_AREA: cfg.elong_area = value[AREA_W-1:0];
        REG_ASPECT_LIMIT:   cfg.aspect_q8  = value[ASPECT_W-1:0];
        default: ;
      endcase
    endfunction

    // Apply the four rules in priority order
    function reason_e judge(logic [AREA_W-1:0] area);
      longint unsigned lhs, rhs, wid, hgt, lng, sht;
      if (area >= cfg.area_max) return RSN_AREA;
      if (zone_sum >= cfg.sum_max) return RSN_SUM;
      if (area >= cfg.dens_area && area != 0) begin
        lhs = zone_sum;
        lhs = lhs << 8;
        rhs = cfg.dens_floor;
        rhs = rhs * area;
        if (lhs < rhs) return RSN_DENSITY;
      end
      if (cfg.elong_on && area >= cfg.elong_area) begin
        wid = (col_hi >= col_lo) ? longint'(col_hi) - longint'(col_lo) + 1 : 1;
        hgt = (row_hi >= row_lo) ? longint'(row_hi) - longint'(row_lo) + 1 : 1;
        lng = (wid > hgt) ? wid : hgt;
        sht = (wid > hgt) ? hgt : wid;
        rhs = cfg.aspect_q8;
        if (lng * 256 >= rhs * sht) return RSN_ELONGATED;
      end
      return RSN_KEPT;
    endfunction

    // Accumulate one accepted pixel request, queue a verdict on zone end
    function void note_pixel(pixel_t p);
      logic [SUM_W:0] wide;
      reason_e        why;
      result_t        verdict;
      if (!p.pixel_signal[SIG_W-1] && p.pixel_signal != '0) begin
        wide = {1'b0, zone_sum} + (SUM_W+1)'(p.pixel_signal[SIG_W-2:0]);
        zone_sum = wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
      end
      if (p.pixel_row < row_lo) row_lo = p.pixel_row;
      if (p.pixel_row > row_hi) row_hi = p.pixel_row;
      if (p.pixel_col < col_lo) col_lo = p.pixel_col;
      if (p.pixel_col > col_hi) col_hi = p.pixel_col;
      if (!p.last_pixel) return;
      why = RSN_KEPT;
      if (cfg.block_on) begin
        why = judge(p.zone_area);
        if (why != RSN_KEPT && frame_rejects < COUNT_MAX_DEF) frame_rejects++;
      end
      verdict.zone_rejected = (why != RSN_KEPT);
      verdict.reject_reason = why;
      verdict.frame_reject_count = COUNT_OUT_W'(frame_rejects);
      owed_q.push_back(verdict);
      clear_zone();
      if (p.last_zone) frame_rejects = 0;
    endfunction

    function void check_verdict(result_t got);
      result_t want;
      if (owed_q.size() == 0) begin
        $error("verdict arrived with no zone end pending");
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.zone_rejected !== want.zone_rejected) begin
        $error("zone_rejected: expected %0d, got %0d", want.zone_rejected,
               got.zone_rejected);
        errors++;
      end
      if (got.reject_reason !== want.reject_reason) begin
        $error("reject_reason: expected %0d, got %0d", want.reject_reason,
               got.reject_reason);
        errors++;
      end
      if (got.frame_reject_count !== want.frame_reject_count) begin
        $error("frame_reject_count: expected %0d, got %0d", want.frame_reject_count,
               got.frame_reject_count);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  pzr_pixel_if  pix ();
  pzr_result_if res ();

  zone_verdicts board = new;
  int unsigned  quiet_cycles = 0;
  int unsigned  stall_req = 0;
  bit           steady = 1'b0;
  bit           moved;

  palm_zone_rejector dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pixel_i  (pix),
    .result_o (res),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Observe both channels and track cycles without progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (pix.valid && pix.ready) begin
        board.note_pixel(pix.payload);
        moved = 1'b1;
      end
      if (res.valid && res.ready) begin
        board.check_verdict(res.payload);
        moved = 1'b1;
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  // Stop a run that makes no progress
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("Mismatches found");
    $finish;
  end

  // Drive verdict ready: random stalls, steady stretches, requested hold-off
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    res.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (stall_req != 0) begin
        hold_left = stall_req;
        stall_req = 0;
      end
      if (hold_left != 0) begin
        res.ready <= 1'b0;
        hold_left--;
      end else begin
        res.ready <= steady || ($urandom_range(99) >= 24);
      end
    end
  end

  // Offer one pixel request and hold it until accepted
  task automatic send_pixel(input pixel_t p);
    while (!steady && $urandom_range(99) < 24) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.payload <= p;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
  endtask

  function automatic pixel_t zone_pixel(int unsigned row, int unsigned col, int sig,
                                        int unsigned area, bit last, bit frame_end);
    pixel_t p;
    p.pixel_row    = COORD_W'(row);
    p.pixel_col    = COORD_W'(col);
    p.pixel_signal = SIG_W'(sig);
    p.zone_area    = AREA_W'(area);
    p.last_pixel   = last;
    p.last_zone    = frame_end;
    return p;
  endfunction

  // Stop offering and wait for every owed verdict
  task automatic await_verdicts();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Write one register: setup cycle, then access cycle until pready
  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.set_reg(idx, value);
  endtask

  // Drain the block, then load a full register setting
  task automatic retune(input tuning_t t);
    await_verdicts();
    repeat (4) @(posedge clk_i);
    write_reg(REG_BLOCK_ENABLED,  CFG_DATA_W'(t.block_on));
    write_reg(REG_AREA_LIMIT,     CFG_DATA_W'(t.area_max));
    write_reg(REG_SUM_LIMIT,      CFG_DATA_W'(t.sum_max));
    write_reg(REG_DENS_MIN_AREA,  CFG_DATA_W'(t.dens_area));
    write_reg(REG_DENS_FLOOR,     CFG_DATA_W'(t.dens_floor));
    write_reg(REG_ELONG_ENABLED,  CFG_DATA_W'(t.elong_on));
    write_reg(REG_ELONG_MIN_AREA, CFG_DATA_W'(t.elong_area));
    write_reg(REG_ASPECT_LIMIT,   CFG_DATA_W'(t.aspect_q8));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Low extreme, high extreme or a value from the useful range
  function automatic int unsigned pick(int unsigned top, int unsigned lo, int unsigned hi);
    case ($urandom_range(9))
      0:       return 0;
      1:       return top;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic tuning_t random_tuning();
    tuning_t t;
    t.block_on   = ($urandom_range(99) < 85);
    t.area_max   = AREA_W'(pick(AREA_MAX, 30, 2400));
    t.sum_max    = SUM_W'(pick(SUM_MAX, 500, 60000));
    t.dens_area  = AREA_W'(pick(AREA_MAX, 0, 60));
    t.dens_floor = FLOOR_W'(pick(FLOOR_MAX, 25600, 640000));
    t.elong_on   = ($urandom_range(3) != 0);
    t.elong_area = AREA_W'(pick(AREA_MAX, 0, 60));
    t.aspect_q8  = ASPECT_W'(pick(ASPECT_MAX, 256, 1800));
    return t;
  endfunction

  function automatic logic [SIG_W-1:0] random_signal();
    case ($urandom_range(19))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return '0;
      3, 4, 5: return SIG_W'(-$urandom_range(32768, 1));
      6, 7:    return SIG_W'($urandom);
      default: return SIG_W'($urandom_range(4000, 1));
    endcase
  endfunction

  function automatic logic [AREA_W-1:0] random_area(int unsigned npix);
    case ($urandom_range(19))
      0:             return '0;
      1, 2, 3, 4:    return AREA_W'($urandom_range(2400));
      5, 6:          return AREA_W'($urandom);
      default:       return AREA_W'($urandom_range(4 * npix + 20, npix));
    endcase
  endfunction

  function automatic int unsigned zone_size();
    return ($urandom_range(99) < 80) ? $urandom_range(6, 1) : $urandom_range(24, 7);
  endfunction

  // Send one zone clustered around a random spot, a few stray pixels
  task automatic random_zone(input int unsigned npix, input bit frame_ok);
    pixel_t      p;
    int unsigned row0, col0, reach;
    row0  = $urandom_range(GRID_ROWS - 1);
    col0  = $urandom_range(GRID_COLS - 1);
    reach = $urandom_range(6);
    for (int unsigned i = 0; i < npix; i++) begin
      if ($urandom_range(99) < 8) begin
        p.pixel_row = COORD_W'($urandom);
        p.pixel_col = COORD_W'($urandom);
      end else begin
        p.pixel_row = COORD_W'(row0 + $urandom_range(reach));
        p.pixel_col = COORD_W'(col0 + $urandom_range(2 * reach));
      end
      p.pixel_signal = random_signal();
      p.zone_area    = random_area(npix);
      p.last_pixel   = (i == npix - 1);
      p.last_zone    = p.last_pixel ? (frame_ok && $urandom_range(99) < 15)
                                    : 1'($urandom_range(1));
      send_pixel(p);
    end
  endtask

  task automatic run_zones(input int unsigned items);
    int unsigned sent, n;
    sent = 0;
    while (sent < items) begin
      n = zone_size();
      random_zone(n, 1'b1);
      sent += n;
    end
  endtask

  // Main sequence
  initial begin
    board.power_on();
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    pix.valid   <= 1'b0;
    pix.payload <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: kept zone, area gate at the top, ignored negatives, frame end
    send_pixel(zone_pixel(0, 0, 32767, 0, 1, 0));
    send_pixel(zone_pixel(63, 63, -32768, 4095, 1, 0));
    send_pixel(zone_pixel(0, 0, -1, 7, 0, 1));
    send_pixel(zone_pixel(39, 59, 1, 0, 0, 0));
    send_pixel(zone_pixel(63, 0, 0, 2400, 1, 1));

    // Each rule in turn at its boundary
    retune('{1'b1, 12'd100, 27'd1000, 12'd10, 23'd12800, 1'b1, 12'd5, 14'd512});
    send_pixel(zone_pixel(3, 3, 10, 100, 1, 0));
    send_pixel(zone_pixel(4, 4, 500, 9, 0, 0));
    send_pixel(zone_pixel(4, 5, 500, 5, 1, 0));
    send_pixel(zone_pixel(6, 6, 499, 10, 1, 0));
    send_pixel(zone_pixel(0, 0, 0, 0, 1, 0));
    send_pixel(zone_pixel(5, 5, 400, 0, 0, 0));
    send_pixel(zone_pixel(5, 15, 500, 8, 1, 0));
    send_pixel(zone_pixel(5, 5, 400, 0, 0, 0));
    send_pixel(zone_pixel(7, 7, 400, 8, 1, 1));

    // Block disabled, density floor at its top and every other limit at its low end
    retune('{1'b0, 12'd0, 27'd0, 12'd0, FLOOR_MAX, 1'b1, 12'd0, 14'd0});
    send_pixel(zone_pixel(20, 30, -5, 50, 1, 0));
    send_pixel(zone_pixel(1, 2, 32767, 4095, 1, 1));

    // Most limits at their high end; a full-width box just reaches the aspect limit
    retune('{1'b1, AREA_MAX, SUM_MAX, AREA_MAX, 23'd0, 1'b1, 12'd0, ASPECT_MAX});
    send_pixel(zone_pixel(10, 0, 100, 3, 0, 0));
    send_pixel(zone_pixel(10, 63, 100, 5, 1, 0));
    send_pixel(zone_pixel(0, 0, 1, 4095, 1, 1));

    // Dense floor at max: zero-area zones fall through to the aspect rule
    retune('{1'b1, AREA_MAX, SUM_MAX, 12'd0, FLOOR_MAX, 1'b1, 12'd0, 14'd0});
    run_zones(25);

    // Random settings; one phase runs without stalls, one pauses midway
    for (int unsigned ph = 0; ph < 6; ph++) begin
      retune(random_tuning());
      steady = (ph == 1);
      if (ph == 3) begin
        run_zones(10);
        await_verdicts();
        run_zones(10);
      end else begin
        run_zones(25);
      end
      steady = 1'b0;
    end

    // Hold off verdicts while single-pixel zones keep coming
    retune(random_tuning());
    stall_req = HOLD_CYCLES;
    repeat (30) random_zone(1, 1'b1);

    // Reject every zone in one long frame to saturate the count
    retune('{1'b1, AREA_MAX, 27'd0, AREA_MAX, 23'd0, 1'b0, AREA_MAX, ASPECT_MAX});
    repeat (265) random_zone(1, 1'b0);
    send_pixel(zone_pixel(0, 0, 0, 1, 1, 1));

    // Build a large zone sum from full-scale pixels
    retune('{1'b1, AREA_MAX, SUM_MAX, AREA_MAX, 23'd0, 1'b0, AREA_MAX, ASPECT_MAX});
    repeat (40) send_pixel(zone_pixel($urandom_range(39), $urandom_range(59),
                                      32767, $urandom_range(4095), 0, 0));
    send_pixel(zone_pixel(20, 20, 32767, 100, 1, 1));
    run_zones(20);

    // Let everything drain, then report
    await_verdicts();
    repeat (8) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
